// ===== hw/rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies.
package spq_pkg;

   localparam int DEPTH_DEF = 16;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_SHOW   = 2'd1;
   localparam logic [1:0] ACT_DRAIN  = 2'd2;

   localparam logic [1:0] STS_INSERTED = 2'd0;
   localparam logic [1:0] STS_GIVEN    = 2'd1;
   localparam logic [1:0] STS_EMPTY    = 2'd2;
   localparam logic [1:0] STS_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [15:0]        tag;
      logic signed [15:0] prio;
   } req_type;

   typedef struct packed {
      logic [15:0]        out_tag;
      logic signed [15:0] out_prio;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       insert;
      logic       list_start;
      logic       rotate;
      logic       clear;
      logic       load;
      logic       give;
      logic [1:0] status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic full;
      logic last_item;
      logic out_free;
   } stat_type;

endpackage

// ===== hw/rtl/spq_dpath.sv =====
// Datapath: sorted shift-register store, fill and list counters, result register.
// Depends on spq_pkg.
module spq_dpath #(
   parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  spq_pkg::req_type req_data,
   input  spq_pkg::cmd_type cmd,
   output spq_pkg::stat_type stat,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic signed [15:0] prio_ff [DEPTH];
   logic signed [15:0] prio_in [DEPTH];
   logic [15:0]        tag_ff  [DEPTH];
   logic [15:0]        tag_in  [DEPTH];
   logic [DEPTH-1:0]   le;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // cell holds an entry that stays ahead of the new one
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le[i] = (CW'(i) < fill_ff) && (prio_ff[i] <= req_data.prio);
      end
   end

   always_comb begin
      int src;
      for (int i = 0; i < DEPTH; i++) begin
         src = (i == DEPTH - 1) ? 0 : i + 1;
         prio_in[i] = prio_ff[i];
         tag_in[i]  = tag_ff[i];
         if (cmd.insert) begin
            if (!le[i]) begin
               if (i == 0) begin
                  prio_in[i] = req_data.prio;
                  tag_in[i]  = req_data.tag;
               end else if (le[(i == 0) ? 0 : i - 1]) begin
                  prio_in[i] = req_data.prio;
                  tag_in[i]  = req_data.tag;
               end else begin
                  prio_in[i] = prio_ff[(i == 0) ? 0 : i - 1];
                  tag_in[i]  = tag_ff[(i == 0) ? 0 : i - 1];
               end
            end
         end else if (cmd.rotate) begin
            // circular shift toward the front over the filled cells
            if (CW'(i) == fill_ff - CW'(1)) begin
               prio_in[i] = prio_ff[0];
               tag_in[i]  = tag_ff[0];
            end else begin
               prio_in[i] = prio_ff[src];
               tag_in[i]  = tag_ff[src];
            end
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.clear) begin
         fill_in = '0;
      end else if (cmd.insert) begin
         fill_in = fill_ff + CW'(1);
      end
      cnt_in = cnt_ff;
      if (cmd.list_start) begin
         cnt_in = '0;
      end else if (cmd.rotate) begin
         cnt_in = cnt_ff + CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.load) begin
         rsp_valid_in    = 1'b1;
         rsp_in.out_tag  = cmd.give ? tag_ff[0] : 16'd0;
         rsp_in.out_prio = cmd.give ? prio_ff[0] : 16'sd0;
         rsp_in.status   = cmd.status;
         rsp_in.last     = cmd.give ? stat.last_item : 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         prio_ff[i] <= prio_in[i];
         tag_ff[i]  <= tag_in[i];
      end
      rsp_ff <= rsp_in;
   end

   assign stat.empty     = (fill_ff == '0);
   assign stat.full      = (fill_ff == CW'(DEPTH));
   assign stat.last_item = (cnt_ff + CW'(1) == fill_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/spq_ctrl.sv =====
// Controller: decodes the action and sequences inserts and listing runs.
// Depends on spq_pkg.
module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        action,
   input  spq_pkg::stat_type stat,
   output spq_pkg::cmd_type  cmd
);
   import spq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LIST = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      drain_ff, drain_in;

   always_comb begin
      state_in  = state_ff;
      drain_in  = drain_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               unique case (action)
                  ACT_INSERT: begin
                     cmd.load   = 1'b1;
                     cmd.insert = !stat.full;
                     cmd.status = stat.full ? STS_FULL : STS_INSERTED;
                  end
                  ACT_SHOW, ACT_DRAIN: begin
                     if (stat.empty) begin
                        cmd.load   = 1'b1;
                        cmd.status = STS_EMPTY;
                     end else begin
                        cmd.list_start = 1'b1;
                        drain_in       = (action == ACT_DRAIN);
                        state_in       = ST_LIST;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LIST: begin
            if (stat.out_free) begin
               cmd.load   = 1'b1;
               cmd.give   = 1'b1;
               cmd.rotate = 1'b1;
               cmd.status = STS_GIVEN;
               if (stat.last_item) begin
                  cmd.clear = drain_ff;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
      end
   end

endmodule

// ===== hw/rtl/sorted_priority_queue_top.sv =====
// Sorted priority queue, top level. Depends on spq_pkg, spq_ctrl, spq_dpath.
// Insert: a parallel compare and shift of the cells; its beat appears the next cycle,
// and a new request is taken every cycle while the result register drains.
// Show/drain: one beat per cycle out of the front cell while the result register drains.
// Reset clears the fill count, list state and result valid; entry cells are not reset.
module sorted_priority_queue_top #(
   parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .action    (req_data.action),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sorted_priority_queue_top_test.sv =====
// Self-checking testbench for sorted_priority_queue_top: a queue-fed driver, a monitor and
// an in-bench model of the sorted store that predicts every response beat.
// Depends on spq_pkg and the sorted_priority_queue_top RTL.
`timescale 1ns / 1ps

module sorted_priority_queue_top_test;
   import spq_pkg::*;

   localparam int DEPTH          = DEPTH_DEF;
   localparam int CLK_PERIOD     = 4;
   localparam int RESET_CYCLES   = 9;
   localparam int RANDOM_BEATS   = 200;
   localparam int PHASE_BEATS    = 50;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 4 * DEPTH + 8;
   localparam int CYCLE_LIMIT    = 400000;

   // action code 3 is not decoded by the block
   localparam logic [1:0] ACT_RESERVED = 2'd3;

   localparam bit [1:0] MODE_FLAT     = 2'd0;
   localparam bit [1:0] MODE_TX_IDLE  = 2'd1;
   localparam bit [1:0] MODE_RX_STALL = 2'd2;
   localparam bit [1:0] MODE_BOTH     = 2'd3;

   typedef struct {
      req_type  beat;
      bit [1:0] mode;
      bit       settle;   // wait until every answer is back before offering
      bit       hold_rx;  // kicks off a long receiver hold-off once accepted
   } stim_item_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   stim_item_type pending[$];
   stim_item_type cur;
   rsp_type       answers_due[$];

   logic signed [15:0] model_prio [DEPTH];
   logic [15:0]        model_tag  [DEPTH];
   int                 model_fill = 0;

   bit [1:0] send_mode  = MODE_FLAT;
   bit       hold_kick  = 1'b0;
   int       hold_left  = 0;
   int       mismatches = 0;
   int       cycle_count = 0;

   sorted_priority_queue_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
   endtask

   // Sorted store: inserts go behind every entry of equal or lower priority.
   function automatic void predict_answers(req_type beat);
      rsp_type r;
      int      pos;
      r = '0;
      r.last = 1'b1;
      case (beat.action)
         ACT_INSERT: begin
            if (model_fill >= DEPTH) begin
               r.status = STS_FULL;
            end else begin
               pos = 0;
               for (int i = 0; i < model_fill; i++) begin
                  if ($signed(model_prio[i]) <= $signed(beat.prio)) pos++;
               end
               for (int i = model_fill; i > pos; i--) begin
                  model_prio[i] = model_prio[i - 1];
                  model_tag[i]  = model_tag[i - 1];
               end
               model_prio[pos] = beat.prio;
               model_tag[pos]  = beat.tag;
               model_fill++;
               r.status = STS_INSERTED;
            end
            answers_due.push_back(r);
         end
         ACT_SHOW, ACT_DRAIN: begin
            if (model_fill == 0) begin
               r.status = STS_EMPTY;
               answers_due.push_back(r);
            end else begin
               for (int i = 0; i < model_fill; i++) begin
                  r.out_tag  = model_tag[i];
                  r.out_prio = model_prio[i];
                  r.status   = STS_GIVEN;
                  r.last     = (i == model_fill - 1);
                  answers_due.push_back(r);
               end
               if (beat.action == ACT_DRAIN) model_fill = 0;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int gap_pct(bit [1:0] mode, bit rx);
      case (mode)
         MODE_TX_IDLE:  return rx ? 0 : 73;
         MODE_RX_STALL: return rx ? 73 : 0;
         MODE_BOTH:     return 27;
         default:       return 0;
      endcase
   endfunction

   function automatic logic [15:0] rand_prio();
      // half the time a narrow band around zero, so equal priorities are common
      if ($urandom_range(0, 1) != 0) return 16'($urandom);
      return 16'($urandom_range(0, 8) - 4);
   endfunction

   task automatic queue_beat(logic [1:0] act, logic [15:0] tag, logic [15:0] prio,
                             bit [1:0] mode, bit settle = 1'b0, bit hold_rx = 1'b0);
      stim_item_type it;
      it.beat.action = act;
      it.beat.tag    = tag;
      it.beat.prio   = prio;
      it.mode        = mode;
      it.settle      = settle;
      it.hold_rx     = hold_rx;
      pending.push_back(it);
   endtask

   // driver
   always @(posedge clock) begin : driver
      bit take;
      bit go;
      if (reset) begin
         req_valid <= 1'b0;
         hold_kick <= 1'b0;
      end else begin
         take = !req_valid || req_ready;
         if (req_valid && req_ready) predict_answers(req_data);
         hold_kick <= req_valid && req_ready && cur.hold_rx;
         if (take) begin
            go = pending.size() != 0;
            if (go && pending[0].settle && answers_due.size() != 0) go = 1'b0;
            if (go && $urandom_range(0, 99) < gap_pct(pending[0].mode, 1'b0)) go = 1'b0;
            if (go) begin
               cur = pending.pop_front();
               req_data  <= cur.beat;
               send_mode <= cur.mode;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, so the block backs up and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= RX_HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               report("unexpected beat", 32'(rsp_data), 32'h0);
            end else begin
               want = answers_due.pop_front();
               if (rsp_data.out_tag !== want.out_tag)
                  report("out_tag", 32'(rsp_data.out_tag), 32'(want.out_tag));
               if (rsp_data.out_prio !== want.out_prio)
                  report("out_prio", 32'(rsp_data.out_prio), 32'(want.out_prio));
               if (rsp_data.status !== want.status)
                  report("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.last !== want.last)
                  report("last", 32'(rsp_data.last), 32'(want.last));
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= gap_pct(send_mode, 1'b1));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[sorted_priority_queue_top] ERROR");
         $finish;
      end
   end

   initial begin
      int       rand_count;
      int       n;
      int       pick;
      bit [1:0] mode;
      bit [1:0] prev_mode;
      logic signed [15:0] fill_prio [16];

      fill_prio = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd1,
                    16'sd32767, -16'sd32768, 16'sd5, 16'sd5, -16'sd1, 16'sd100,
                    -16'sd100, 16'sd0, 16'sd32766};

      // directed: empty store, ignored code, fill with extremes and ties, full, list
      queue_beat(ACT_SHOW, 16'hFFFF, 16'hFFFF, MODE_FLAT);
      queue_beat(ACT_DRAIN, 16'h0000, 16'h0000, MODE_FLAT);
      queue_beat(ACT_RESERVED, 16'hFFFF, 16'h8000, MODE_FLAT);
      for (int i = 0; i < DEPTH; i++) begin
         queue_beat(ACT_INSERT, (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'(i * 16'h1111 + 3),
                    fill_prio[i % 16], MODE_FLAT);
      end
      queue_beat(ACT_INSERT, 16'hABCD, 16'h7FFF, MODE_FLAT);
      queue_beat(ACT_SHOW, 16'h5555, 16'hAAAA, MODE_FLAT);
      queue_beat(ACT_DRAIN, 16'hAAAA, 16'h5555, MODE_FLAT);
      queue_beat(ACT_SHOW, 16'h0000, 16'h0000, MODE_FLAT);

      // pressure: receiver held off while inserts keep coming past the full point
      queue_beat(ACT_INSERT, 16'($urandom), rand_prio(), MODE_FLAT, 1'b1, 1'b1);
      repeat (DEPTH + 8) queue_beat(ACT_INSERT, 16'($urandom), rand_prio(), MODE_FLAT);
      queue_beat(ACT_DRAIN, 16'($urandom), 16'($urandom), MODE_FLAT);

      // random bursts of inserts, each followed by a list or an ignored code, through the idling phases
      rand_count = 0;
      prev_mode  = MODE_FLAT;
      while (rand_count < RANDOM_BEATS) begin
         mode = 2'((rand_count / PHASE_BEATS) % 4);
         n = $urandom_range(0, DEPTH + 2);
         for (int i = 0; i < n; i++) begin
            queue_beat(ACT_INSERT, 16'($urandom), rand_prio(), mode, mode != prev_mode);
            prev_mode = mode;
            rand_count++;
         end
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            queue_beat(ACT_SHOW, 16'($urandom), 16'($urandom), mode, mode != prev_mode);
            rand_count++;
         end else if (pick < 9) begin
            queue_beat(ACT_DRAIN, 16'($urandom), 16'($urandom), mode, mode != prev_mode);
            rand_count++;
         end else begin
            queue_beat(ACT_RESERVED, 16'($urandom), 16'($urandom), mode);
         end
         prev_mode = mode;
      end
      queue_beat(ACT_DRAIN, 16'($urandom), 16'($urandom), MODE_FLAT);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_valid || answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("[sorted_priority_queue_top] OK");
      end else begin
         $display("[sorted_priority_queue_top] ERROR");
      end
      $finish;
   end

endmodule
